>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl of the arp reply host collector
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/arphc_pkg.sv
// shared types and constants for the arp reply host collector
// no dependencies
package arphc_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int CELL_COUNT   = 8;
    localparam int CELL_ENTRIES = (TABLE_DEPTH + CELL_COUNT - 1) / CELL_COUNT;

    localparam int CID_W   = $clog2(CELL_COUNT);
    localparam int EIDX_W  = (CELL_ENTRIES > 1) ? $clog2(CELL_ENTRIES) : 1;
    localparam int GX_W    = $clog2(CELL_COUNT * CELL_ENTRIES) + 1;
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;

    localparam logic [10:0] MIN_FRAME_LEN = 11'd42;
    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] OPCODE_REPLY  = 16'd2;

    // register index as decoded from paddr[2]
    localparam logic REG_OWN_IP = 1'b0;

    typedef enum logic [2:0] {
        ST_RECORDED  = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NOT_ARP   = 3'd2,
        ST_NOT_REPLY = 3'd3,
        ST_OWN       = 3'd4,
        ST_DUPLICATE = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SEARCH,
        CS_FINISH
    } ctrl_state_t;

    // lookup token that walks the cell chain
    typedef struct packed {
        logic            active;
        logic [IP_W-1:0] ip;
        logic            found;
        logic [GX_W-1:0] idx;
    } search_tok_t;

    // table write broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [GX_W-1:0]  idx;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } tbl_wr_t;

endpackage

>>> rtl/arphc_cell.sv
// one cell of the host table chain: a slice of stored hosts and a lookup stage
// depends on arphc_pkg
module arphc_cell
    import arphc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CID_W-1:0]  cell_id,
    input  logic [GX_W-1:0]   fill,
    input  tbl_wr_t           wr,
    input  search_tok_t       tok_in,
    output search_tok_t       tok_out
);

    logic [IP_W-1:0]   ip_reg  [CELL_ENTRIES];
    logic [MAC_W-1:0]  mac_reg [CELL_ENTRIES];
    logic [GX_W-1:0]   base;
    logic [GX_W-1:0]   entry_gidx [CELL_ENTRIES];
    logic [CELL_ENTRIES-1:0] hit_vec;
    logic              hit_found;
    logic [EIDX_W-1:0] hit_e;
    search_tok_t       tok_reg;
    search_tok_t       tok_next;

    assign base = GX_W'(cell_id) * GX_W'(CELL_ENTRIES);

    always_comb
    begin
        for (int e = 0; e < CELL_ENTRIES; e++)
        begin
            entry_gidx[e] = base + GX_W'(e);
            // entries at or past the fill point were never written
            hit_vec[e] = (entry_gidx[e] < fill) && (ip_reg[e] == tok_in.ip);
        end
    end

    // lowest matching entry wins
    always_comb
    begin
        hit_found = 1'b0;
        hit_e     = '0;
        for (int e = CELL_ENTRIES - 1; e >= 0; e--)
        begin
            if (hit_vec[e])
            begin
                hit_found = 1'b1;
                hit_e     = EIDX_W'(e);
            end
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && !tok_in.found && hit_found)
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = base + GX_W'(hit_e);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int e = 0; e < CELL_ENTRIES; e++)
        begin
            if (wr.en && (wr.idx == entry_gidx[e]))
            begin
                ip_reg[e]  <= wr.ip;
                mac_reg[e] <= wr.mac;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/arp_reply_host_collector_core.sv
// arp reply host collector top: header checks, cell chain of the host table, apb register
// rejected frames: the result is loaded to the result register, then the output register
// arp replies: the token passes the register in each cell of the 8-cell lookup chain,
// then the result and output registers; a new frame waits until the last one is through
// a result still stalled in the output register holds the next one back
// async active-low reset clears host count, own ip, control and valid state; table is unset
`include "assert_macros.svh"

module arp_reply_host_collector_core
    import arphc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,

    input  logic         frame_valid,
    output logic         frame_stall,
    input  logic [10:0]  frame_length,
    input  logic [15:0]  ether_type,
    input  logic [15:0]  arp_opcode,
    input  logic [31:0]  peer_ip,
    input  logic [47:0]  sender_mac,

    output logic         result_valid,
    input  logic         result_stall,
    output logic [2:0]   status,
    output logic [7:0]   slot,
    output logic [8:0]   host_count
);

    ctrl_state_t        state_reg;
    ctrl_state_t        state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [IP_W-1:0]    own_ip_reg;
    logic [MAC_W-1:0]   mac_hold_reg;

    status_t            res_status_reg;
    status_t            res_status_next;
    logic [7:0]         res_slot_reg;
    logic [7:0]         res_slot_next;
    logic [8:0]         res_count_reg;
    logic [8:0]         res_count_next;
    logic               load_res;

    logic               result_valid_reg;
    status_t            out_status_reg;
    logic [7:0]         out_slot_reg;
    logic [8:0]         out_count_reg;
    logic               out_load;

    logic               frame_accept;
    logic               pass_checks;
    status_t            pre_status;
    logic               cfg_write;

    search_tok_t        tok_chain [CELL_COUNT+1];
    search_tok_t        launch;
    search_tok_t        tok_last;
    tbl_wr_t            wr;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_OWN_IP) ? own_ip_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == REG_OWN_IP))
        begin
            own_ip_reg <= pwdata;
        end
    end

    // header checks, first failing one decides
    always_comb
    begin
        priority if (frame_length < MIN_FRAME_LEN)
            pre_status = ST_SHORT;
        else if (ether_type != ETHERTYPE_ARP)
            pre_status = ST_NOT_ARP;
        else if (arp_opcode != OPCODE_REPLY)
            pre_status = ST_NOT_REPLY;
        else if (peer_ip == own_ip_reg)
            pre_status = ST_OWN;
        else
            pre_status = ST_RECORDED;
    end

    assign pass_checks  = (pre_status == ST_RECORDED);
    assign frame_stall  = (state_reg != CS_IDLE);
    assign frame_accept = frame_valid && !frame_stall;

    // lookup chain
    assign tok_chain[0] = launch;
    assign tok_last     = tok_chain[CELL_COUNT];

    for (genvar c = 0; c < CELL_COUNT; c++)
    begin : g_cell
        arphc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_id (CID_W'(c)),
            .fill    (GX_W'(count_reg)),
            .wr      (wr),
            .tok_in  (tok_chain[c]),
            .tok_out (tok_chain[c+1])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        launch.active   = 1'b0;
        launch.ip       = peer_ip;
        launch.found    = 1'b0;
        launch.idx      = '0;
        wr.en           = 1'b0;
        wr.idx          = GX_W'(count_reg);
        wr.ip           = tok_last.ip;
        wr.mac          = mac_hold_reg;
        load_res        = 1'b0;
        res_status_next = pre_status;
        res_slot_next   = '0;
        res_count_next  = 9'(count_reg);
        out_load        = 1'b0;

        unique case (state_reg)
            CS_IDLE:
            begin
                if (frame_accept)
                begin
                    if (pass_checks)
                    begin
                        launch.active = 1'b1;
                        state_next    = CS_SEARCH;
                    end
                    else
                    begin
                        load_res   = 1'b1;
                        state_next = CS_FINISH;
                    end
                end
            end
            CS_SEARCH:
            begin
                if (tok_last.active)
                begin
                    load_res   = 1'b1;
                    state_next = CS_FINISH;
                    priority if (tok_last.found)
                    begin
                        res_status_next = ST_DUPLICATE;
                        res_slot_next   = 8'(tok_last.idx);
                    end
                    else if (count_reg == COUNT_W'(TABLE_DEPTH))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        wr.en           = 1'b1;
                        count_next      = count_reg + COUNT_W'(1);
                        res_status_next = ST_RECORDED;
                        res_slot_next   = 8'(count_reg);
                        res_count_next  = 9'(count_next);
                    end
                end
            end
            CS_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= CS_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_accept)
            mac_hold_reg <= sender_mac;
        if (load_res)
        begin
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_count_reg  <= res_count_next;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_count_reg  <= res_count_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = out_status_reg;
    assign slot         = out_slot_reg;
    assign host_count   = out_count_reg;

    `ASSERT_IMPL(a_tok_in_search, tok_last.active, state_reg == CS_SEARCH,
                 "lookup token outside search")
    `ASSERT_ALWAYS(a_count_bound, count_reg <= COUNT_W'(TABLE_DEPTH),
                   "host count past table depth")
    `ASSERT_IMPL(a_write_room, wr.en, count_reg < COUNT_W'(TABLE_DEPTH),
                 "table write with no room")
    `ASSERT_NEXT(a_pass_launch, frame_accept && pass_checks, tok_chain[1].active,
                 "reply beat did not start a lookup")
    `ASSERT_NEXT(a_count_step, wr.en, count_reg == $past(count_reg) + COUNT_W'(1),
                 "host count did not step on a write")

endmodule
